FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/itra_pkg.sv
package itra_pkg;

  typedef logic [5:0] digit_t;
  typedef logic [6:0] char_t;

  localparam char_t CHAR_ZERO  = 7'h30;
  localparam char_t CHAR_NINE  = 7'h39;
  localparam char_t CHAR_A     = 7'h41;
  localparam char_t CHAR_Z     = 7'h5A;
  localparam char_t CHAR_MINUS = 7'h2D;

  localparam digit_t RADIX_MIN   = 6'd2;
  localparam digit_t RADIX_MAX   = 6'd36;
  localparam digit_t RADIX_RESET = 6'd10;
  localparam digit_t DECIMAL     = 6'd10;
  localparam digit_t DIGIT_NINE  = 6'd9;

  typedef struct packed {
    logic load;      // take a new number, clear the digit cells
    logic convert;   // one doubling step of the digit cells
    logic shift;     // move the digit column up by one cell
    logic load_out;  // write the output register
    logic out_sign;  // output register gets '-'
    logic out_last;  // output register gets the last flag
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic top_nonzero;
  } dp_status_t;

  function automatic digit_t sat_radix(input logic [5:0] r);
    digit_t res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic char_t digit_char(input digit_t d);
    char_t res;
    digit_t above_nine;
    above_nine = d - DECIMAL;
    if (d <= DIGIT_NINE) res = CHAR_ZERO + 7'(d);
    else res = CHAR_A + 7'(above_nine);
    return res;
  endfunction

endpackage

FILE: rtl/integer_to_radix_ascii_unit.sv
// Converts a signed integer to ASCII text in base radix (2 to 36, saturated at both ends;
// reset value 10), most significant character first, with last set on the final character.
// Digits above nine are upper-case letters. Only base ten shows a negative value as '-'
// and its magnitude; other bases print the two's-complement pattern as unsigned.
// One number at a time: a row of NUMBER_WIDTH base-r digit cells takes the magnitude one
// bit per cycle, and its carries ripple up one cell per cycle. The digit column then
// shifts up one cell per cycle unless the output stalls; leading zero cells are dropped,
// and a '-' goes out first for a negative base-ten value.
// A new number is taken while the last character still waits in the output register.
module integer_to_radix_ascii_unit import itra_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_enable,
  input  logic [5:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] number,
  output logic                    out_valid,
  input  logic                    out_stall,
  output char_t                   character,
  output logic                    last
);

  `include "assert_macros.svh"

  logic [5:0] radix;
  digit_t     radix_eff;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_enable) begin
      radix <= cfg_data;
    end
  end

  assign radix_eff = sat_radix(radix);

  itra_ctrl #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  itra_dp #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_dp (
    .clk      (clk),
    .number   (number),
    .radix_eff(radix_eff),
    .cmd      (cmd),
    .status   (status),
    .character(character),
    .last     (last)
  );

  // a transaction on the input starts a conversion that holds off the next one
  `ASSERT_NEXT_CYCLE(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // when ready for a new number, a pending character can only be the final one
  `ASSERT_SAME_CYCLE(a_idle_only_last, out_valid && !in_stall, last)
  // a sign is never the whole text
  `ASSERT_SAME_CYCLE(a_sign_not_last, out_valid && character == CHAR_MINUS, !last)
  `ASSERT_SAME_CYCLE(a_char_set, out_valid,
    character == CHAR_MINUS || (character >= CHAR_ZERO && character <= CHAR_NINE) ||
    (character >= CHAR_A && character <= CHAR_Z))

endmodule

FILE: rtl/itra_dp.sv
module itra_dp import itra_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  digit_t                  radix_eff,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output char_t                   character,
  output logic                    last
);

  logic [NUMBER_WIDTH-1:0] mag_sr;
  logic [NUMBER_WIDTH-1:0] pend;
  logic                    neg;
  logic                    neg_now;
  digit_t                  digits [NUMBER_WIDTH];
  logic [NUMBER_WIDTH-1:0] carry;
  logic [NUMBER_WIDTH-1:0] act_in;

  assign neg_now = (radix_eff == DECIMAL) && number[NUMBER_WIDTH-1];

  // magnitude bits go in msb first; pend marks the cycles that still carry a bit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_sr <= neg_now ? (~number + 1'b1) : number;
      pend   <= '1;
      neg    <= neg_now;
    end else if (cmd.convert) begin
      mag_sr <= {mag_sr[NUMBER_WIDTH-2:0], 1'b0};
      pend   <= {pend[NUMBER_WIDTH-2:0], 1'b0};
    end
  end

  // row of base-r digit cells, each doubles and adds the carry of the cell below;
  // cell j's active flag is a registered copy of cell j-1's, and carries pass through cy
  for (genvar j = 0; j < NUMBER_WIDTH; j++) begin : g_cell
    digit_t     dig;
    digit_t     below;
    logic       cy;
    logic       cin;
    logic [6:0] sum;
    logic [6:0] diff;
    logic       ge;

    if (j == 0) begin : g_first
      assign cin       = mag_sr[NUMBER_WIDTH-1];
      assign act_in[j] = pend[NUMBER_WIDTH-1];
      assign below     = '0;
    end else begin : g_rest
      logic act;
      assign cin       = carry[j-1];
      assign act_in[j] = act;
      assign below     = digits[j-1];
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          act <= 1'b1;
        end else if (cmd.convert) begin
          act <= act_in[j-1];
        end
      end
    end

    assign sum  = {dig, 1'b0} + 7'(cin);
    assign diff = sum - {1'b0, radix_eff};
    assign ge   = sum >= {1'b0, radix_eff};

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        dig <= '0;
        cy  <= 1'b0;
      end else if (cmd.convert) begin
        if (act_in[j]) begin
          dig <= ge ? diff[5:0] : sum[5:0];
          cy  <= ge;
        end else begin
          cy  <= 1'b0;
        end
      end else if (cmd.shift) begin
        dig <= below;
      end
    end

    assign digits[j] = dig;
    assign carry[j]  = cy;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      character <= cmd.out_sign ? CHAR_MINUS : digit_char(digits[NUMBER_WIDTH-1]);
      last      <= cmd.out_last;
    end
  end

  assign status.neg         = neg;
  assign status.top_nonzero = digits[NUMBER_WIDTH-1] != '0;

endmodule

FILE: rtl/itra_ctrl.sv
module itra_ctrl import itra_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int CNT_W = $clog2(2 * NUMBER_WIDTH - 1);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * NUMBER_WIDTH - 2);
  localparam logic [CNT_W-1:0] EMIT_LAST = CNT_W'(NUMBER_WIDTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             started, started_next;
  logic             out_valid_next;
  logic             out_free;
  logic             emit_now;

  assign out_free = !out_valid || !out_stall;
  // leading zero cells are dropped, but the bottom cell always gives a character
  assign emit_now = started || status.top_nonzero || (cnt == '0);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cnt_next     = cnt;
    started_next = started;
    in_stall     = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cnt_next     = CONV_LAST;
          started_next = 1'b0;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.convert = 1'b1;
        if (cnt == '0) begin
          cnt_next   = EMIT_LAST;
          state_next = status.neg ? S_SIGN : S_EMIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sign = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_now) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.shift    = 1'b1;
            cmd.out_last = cnt == '0;
            started_next = 1'b1;
            if (cnt == '0) state_next = S_IDLE;
            else cnt_next = cnt - 1'b1;
          end
        end else begin
          cmd.shift = 1'b1;
          cnt_next  = cnt - 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      started   <= started_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: test/tb_integer_to_radix_ascii_unit.sv
`timescale 1ns / 100ps

module tb_integer_to_radix_ascii_unit;
  import itra_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_char_t;

  class char_scoreboard;
    text_char_t expected_q[$];
    int mismatches;
    int chars_checked;
    int numbers_noted;

    function new();
      mismatches = 0;
      chars_checked = 0;
      numbers_noted = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // expected text of one number in the given base, most significant first
    function void note_number(input logic [31:0] value, input logic [5:0] radix_value);
      int unsigned base;
      logic [31:0] mag;
      logic [5:0] dig;
      logic negative;
      char_t digit_q[$];
      text_char_t entry;
      if (radix_value < RADIX_MIN) base = RADIX_MIN;
      else if (radix_value > RADIX_MAX) base = RADIX_MAX;
      else base = radix_value;
      negative = (base == DECIMAL) && value[31];
      // the most negative value wraps to its own correct magnitude
      mag = negative ? (32'd0 - value) : value;
      if (negative) begin
        entry.ch = CHAR_MINUS;
        entry.last = 1'b0;
        expected_q.push_back(entry);
      end
      if (mag == 0) digit_q.push_front(CHAR_ZERO);
      while (mag != 0) begin
        dig = 6'(mag % base);
        if (dig <= DIGIT_NINE) digit_q.push_front(CHAR_ZERO + 7'(dig));
        else digit_q.push_front(CHAR_A + 7'(dig - DECIMAL));
        mag = mag / base;
      end
      foreach (digit_q[i]) begin
        entry.ch = digit_q[i];
        entry.last = (i == digit_q.size() - 1);
        expected_q.push_back(entry);
      end
      numbers_noted++;
    endfunction

    task check_char(input char_t ch, input logic lst);
      text_char_t entry;
      chars_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected character 0x%h last %b", ch, lst));
      end else begin
        entry = expected_q.pop_front();
        if (entry.ch !== ch)
          report($sformatf("character 0x%h, expected 0x%h", ch, entry.ch));
        if (entry.last !== lst)
          report($sformatf("last %b, expected %b on 0x%h", lst, entry.last, entry.ch));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_enable;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] number;
  logic        out_valid;
  logic        out_stall;
  char_t       character;
  logic        last;

  char_scoreboard sb;
  logic [5:0] cur_radix;
  bit idle_enable;
  int receiver_hold;
  int cycle_count;
  int radix_settings;

  integer_to_radix_ascii_unit #(.NUMBER_WIDTH(32)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_enable (cfg_enable),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < WATCHDOG_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_hold > 0) begin
        out_stall <= 1'b1;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(character, last);
  end

  task write_radix(input logic [5:0] value);
    cfg_enable <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_enable <= 1'b0;
    cur_radix = value;
    radix_settings++;
  endtask

  task send_number(input logic [31:0] value);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    number <= value;
    do @(posedge clk); while (in_stall);
    sb.note_number(value, cur_radix);
  endtask

  // drop valid, wait for every character of the batch, then let the block settle
  task finish_batch();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_number();
    logic [31:0] value;
    case ($urandom_range(0, 6))
      0, 1: value = $urandom;
      2: value = $urandom_range(0, 40);
      3: value = 32'd0 - $urandom_range(1, 40);
      4: value = {1'b1, 31'($urandom)};
      5: value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      default: begin
        case ($urandom_range(0, 3))
          0: value = 32'd0;
          1: value = 32'hffff_ffff;
          2: value = INT_MIN;
          default: value = INT_MAX;
        endcase
      end
    endcase
    return value;
  endfunction

  function automatic logic [5:0] rand_radix();
    logic [5:0] value;
    case ($urandom_range(0, 5))
      0: value = RADIX_MIN;
      1: value = RADIX_MAX;
      2: value = DECIMAL;
      3: value = 6'd16;
      default: value = 6'($urandom_range(0, 63));
    endcase
    return value;
  endfunction

  initial begin
    sb = new();
    cycle_count = 0;
    radix_settings = 0;
    receiver_hold = 0;
    idle_enable = 1'b1;
    cur_radix = RADIX_RESET;
    rst <= 1'b1;
    cfg_enable <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    number <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // base ten from reset: sign handling and the most negative value
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hffff_ffff);
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'hffff_fff6);
    send_number(INT_MIN);
    send_number(INT_MAX);
    finish_batch();

    // binary: longest text, negative read as unsigned
    write_radix(RADIX_MIN);
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hffff_ffff);
    send_number(INT_MIN);
    finish_batch();

    // base 36: top letter and digit rollover
    write_radix(RADIX_MAX);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'hffff_ffff);
    send_number(INT_MAX);
    send_number(32'hffff_ffdc);
    finish_batch();

    // radix below two saturates to binary
    write_radix(6'd0);
    send_number(32'd5);
    send_number(32'hffff_ffff);
    finish_batch();
    write_radix(6'd1);
    send_number(32'd3);
    finish_batch();

    // radix above 36 saturates to 36
    write_radix(6'd63);
    send_number(32'd35);
    send_number(INT_MIN);
    finish_batch();
    write_radix(6'd37);
    send_number(32'd71);
    finish_batch();

    for (int phase = 0; phase < 8; phase++) begin
      write_radix(rand_radix());
      if (phase >= 6) idle_enable = 1'b0;
      if (phase == 3) begin
        // long output hold-off while the sender keeps offering
        receiver_hold = 300;
        repeat (6) send_number(rand_number());
      end
      repeat (16) send_number(rand_number());
      finish_batch();
    end

    repeat (100) @(posedge clk);
    $display("converted %0d numbers into %0d characters across %0d radix writes",
             sb.numbers_noted, sb.chars_checked, radix_settings);
    $display("covered saturated radix values, base ten signs and a long output stall");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
